[src/assert_macros.svh]
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

[src/ffha_pkg.sv]
// Types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int HeapUnits   = 4096;
  localparam int HeaderUnits = 2;
  localparam int UnitShift   = 3;

  localparam int ReqW   = 16;
  localparam int OffW   = 15;
  localparam int AddrW  = $clog2(HeapUnits);
  localparam int PosW   = AddrW + 1;            // unit position, can reach HeapUnits
  localparam int SizeW  = AddrW + 1;            // payload size in units
  localparam int HdrW   = SizeW + 1;
  localparam int UnitsW = ReqW - UnitShift + 1; // rounded request in units
  localparam int SumW   = PosW + 1;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusNoFit = 1'b1;

  typedef struct packed {
    logic             used;
    logic [SizeW-1:0] size;
  } hdr_t;

  localparam hdr_t HdrReset = '{used: 1'b0, size: SizeW'(HeapUnits - HeaderUnits)};

endpackage

[src/ffha_if.sv]
// Request and response channel interfaces.
interface ffha_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [ffha_pkg::ReqW-1:0]   request_bytes;
  logic [ffha_pkg::OffW-1:0]   free_offset;

  modport source (output valid, output op, output request_bytes, output free_offset,
                  input ready);
  modport sink   (input valid, input op, input request_bytes, input free_offset,
                  output ready);
endinterface

interface ffha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [ffha_pkg::OffW-1:0]   payload_offset;

  modport source (output valid, output status, output payload_offset, input ready);
  modport sink   (input valid, input status, input payload_offset, output ready);
endinterface

[src/first_fit_heap_allocator.sv]
// First-fit heap allocator: header walk, split and coalescing over a header RAM.
//
//  channel | dir | fields                                  | transfer when
//  --------+-----+-----------------------------------------+-----------------
//  req_i   | in  | op, request_bytes, free_offset          | valid & ready
//  rsp_o   | out | status, payload_offset                  | valid & ready
//
// Walks read one block header per cycle from the header RAM, a registered read.
// Allocate walks the blocks up to the first fit, or to the heap end on no fit.
// Free walks to the target block, then runs a coalescing walk over all blocks;
// both walks go over the single RAM read port.
// Reset: one flag marks unit 0 as holding the initial whole-heap free block until
// written; no clearing pass. A new request is taken only in idle; a finished result
// waits in the output register while the next request is accepted.
`include "assert_macros.svh"

module first_fit_heap_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffha_req_if.sink   req_i,
  ffha_rsp_if.source rsp_o
);

  localparam logic [2:0] StIdle      = 3'd0;
  localparam logic [2:0] StWalk      = 3'd1;
  localparam logic [2:0] StCoalStart = 3'd2;
  localparam logic [2:0] StCoal      = 3'd3;
  localparam logic [2:0] StSplit     = 3'd4;
  localparam logic [2:0] StFin       = 3'd5;

  localparam int RoundW = ffha_pkg::ReqW + 1;

  // Control state
  logic [2:0]                  state_q, state_d;
  logic                        out_valid_q, out_valid_d;
  logic                        init0_q, init0_d;   // unit 0 still holds its reset header
  logic                        rd0_q;              // last read was of unit 0
  logic [ffha_pkg::PosW-1:0]   addr_q, addr_d;     // unit whose header arrives now
  logic                        first_q, first_d;
  logic                        dirty_q, dirty_d;

  // Payload state
  logic                        op_q, op_d;
  logic [ffha_pkg::UnitsW-1:0] units_q, units_d;
  logic [ffha_pkg::UnitsW-1:0] need_q, need_d;
  logic [ffha_pkg::AddrW-1:0]  target_q, target_d;
  logic [ffha_pkg::AddrW-1:0]  cur_addr_q, cur_addr_d;
  logic                        cur_used_q, cur_used_d;
  logic [ffha_pkg::SizeW-1:0]  cur_size_q, cur_size_d;
  logic [ffha_pkg::AddrW-1:0]  split_addr_q, split_addr_d;
  logic [ffha_pkg::SizeW-1:0]  rest_q, rest_d;
  logic                        res_status_q, res_status_d;
  logic [ffha_pkg::OffW-1:0]   res_off_q, res_off_d;
  logic                        out_status_q, out_status_d;
  logic [ffha_pkg::OffW-1:0]   out_off_q, out_off_d;

  // RAM port
  logic                        ram_we, ram_re;
  logic [ffha_pkg::AddrW-1:0]  ram_waddr, ram_raddr;
  ffha_pkg::hdr_t              ram_wdata;
  logic [ffha_pkg::HdrW-1:0]   ram_rdata;

  ffha_pkg::hdr_t              hdr;
  logic [ffha_pkg::SumW-1:0]   nxt_w;
  logic                        past_end;
  logic [ffha_pkg::PosW-1:0]   pay_pos;
  logic [RoundW-1:0]           rounded;
  logic [ffha_pkg::SizeW-1:0]  merged;
  logic                        fits;
  logic                        out_free;

  ffha_ram #(
    .Width (ffha_pkg::HdrW),
    .Depth (ffha_pkg::HeapUnits)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Unit 0 reads as the whole-heap free block until first written.
  assign hdr = (rd0_q && init0_q) ? ffha_pkg::HdrReset : ffha_pkg::hdr_t'(ram_rdata);

  // Start of the block after the one just read.
  assign nxt_w    = {1'b0, addr_q} + ffha_pkg::SumW'(ffha_pkg::HeaderUnits)
                  + {{(ffha_pkg::SumW - ffha_pkg::SizeW){1'b0}}, hdr.size};
  assign past_end = nxt_w >= ffha_pkg::SumW'(ffha_pkg::HeapUnits);
  assign pay_pos  = addr_q + ffha_pkg::PosW'(ffha_pkg::HeaderUnits);
  assign fits     = !hdr.used && ({{(ffha_pkg::UnitsW - ffha_pkg::SizeW){1'b0}}, hdr.size}
                                  >= need_q);
  assign merged   = cur_size_q + ffha_pkg::SizeW'(ffha_pkg::HeaderUnits) + hdr.size;
  assign rounded  = {1'b0, req_i.request_bytes} + RoundW'((1 << ffha_pkg::UnitShift) - 1);

  assign req_i.ready          = (state_q == StIdle);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.payload_offset = out_off_q;
  assign out_free             = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    init0_d      = init0_q;
    addr_d       = addr_q;
    first_d      = first_q;
    dirty_d      = dirty_q;
    op_d         = op_q;
    units_d      = units_q;
    need_d       = need_q;
    target_d     = target_q;
    cur_addr_d   = cur_addr_q;
    cur_used_d   = cur_used_q;
    cur_size_d   = cur_size_q;
    split_addr_d = split_addr_q;
    rest_d       = rest_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    out_status_d = out_status_q;
    out_off_d    = out_off_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          op_d         = req_i.op;
          units_d      = rounded[RoundW-1:ffha_pkg::UnitShift];
          need_d       = rounded[RoundW-1:ffha_pkg::UnitShift]
                       + ffha_pkg::UnitsW'(ffha_pkg::HeaderUnits);
          target_d     = req_i.free_offset[ffha_pkg::OffW-1:ffha_pkg::UnitShift];
          res_status_d = ffha_pkg::StatusOk;
          res_off_d    = '0;
          if (req_i.op == ffha_pkg::OpAlloc ||
              req_i.free_offset[ffha_pkg::UnitShift-1:0] == '0) begin
            ram_re  = 1'b1;
            addr_d  = '0;
            state_d = StWalk;
          end else begin
            // unaligned free: nothing to find, coalescing still runs
            state_d = StCoalStart;
          end
        end
      end

      StWalk: begin
        if (op_q == ffha_pkg::OpAlloc) begin
          if (fits) begin
            ram_we       = 1'b1;
            ram_waddr    = addr_q[ffha_pkg::AddrW-1:0];
            ram_wdata    = '{used: 1'b1, size: units_q[ffha_pkg::SizeW-1:0]};
            split_addr_d = ffha_pkg::AddrW'(pay_pos + units_q[ffha_pkg::SizeW-1:0]);
            rest_d       = hdr.size - need_q[ffha_pkg::SizeW-1:0];
            res_off_d    = {pay_pos[ffha_pkg::OffW-ffha_pkg::UnitShift-1:0],
                            {ffha_pkg::UnitShift{1'b0}}};
            state_d      = StSplit;
          end else if (past_end) begin
            res_status_d = ffha_pkg::StatusNoFit;
            state_d      = StFin;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = nxt_w[ffha_pkg::AddrW-1:0];
            addr_d    = nxt_w[ffha_pkg::PosW-1:0];
          end
        end else begin
          if (pay_pos == {1'b0, target_q}) begin
            ram_we    = 1'b1;
            ram_waddr = addr_q[ffha_pkg::AddrW-1:0];
            ram_wdata = '{used: 1'b0, size: hdr.size};
            state_d   = StCoalStart;
          end else if (past_end) begin
            state_d = StCoalStart;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = nxt_w[ffha_pkg::AddrW-1:0];
            addr_d    = nxt_w[ffha_pkg::PosW-1:0];
          end
        end
      end

      StSplit: begin
        // remainder of the split block, possibly empty
        ram_we    = 1'b1;
        ram_waddr = split_addr_q;
        ram_wdata = '{used: 1'b0, size: rest_q};
        state_d   = StFin;
      end

      StCoalStart: begin
        ram_re  = 1'b1;
        addr_d  = '0;
        first_d = 1'b1;
        dirty_d = 1'b0;
        state_d = StCoal;
      end

      StCoal: begin
        if (!first_q && !cur_used_q && !hdr.used) begin
          // absorb this block into the held free block
          cur_size_d = merged;
          dirty_d    = 1'b1;
          if (past_end) begin
            ram_we    = 1'b1;
            ram_waddr = cur_addr_q;
            ram_wdata = '{used: 1'b0, size: merged};
            state_d   = StFin;
          end
        end else begin
          if (dirty_q) begin
            ram_we    = 1'b1;
            ram_waddr = cur_addr_q;
            ram_wdata = '{used: 1'b0, size: cur_size_q};
          end
          cur_addr_d = addr_q[ffha_pkg::AddrW-1:0];
          cur_used_d = hdr.used;
          cur_size_d = hdr.size;
          dirty_d    = 1'b0;
          first_d    = 1'b0;
          if (past_end) begin
            state_d = StFin;
          end
        end
        if (!past_end) begin
          ram_re    = 1'b1;
          ram_raddr = nxt_w[ffha_pkg::AddrW-1:0];
          addr_d    = nxt_w[ffha_pkg::PosW-1:0];
        end
      end

      StFin: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_off_d    = res_off_q;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    if (ram_we && ram_waddr == '0) begin
      init0_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      init0_q     <= 1'b1;
      rd0_q       <= 1'b0;
      addr_q      <= '0;
      first_q     <= 1'b0;
      dirty_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      init0_q     <= init0_d;
      rd0_q       <= ram_re && (ram_raddr == '0);
      addr_q      <= addr_d;
      first_q     <= first_d;
      dirty_q     <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    units_q      <= units_d;
    need_q       <= need_d;
    target_q     <= target_d;
    cur_addr_q   <= cur_addr_d;
    cur_used_q   <= cur_used_d;
    cur_size_q   <= cur_size_d;
    split_addr_q <= split_addr_d;
    rest_q       <= rest_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    out_status_q <= out_status_d;
    out_off_q    <= out_off_d;
  end

  // A header is never read and written at the same unit in one cycle.
  `ASSERT_NEVER(a_no_rw_clash, clk_i, rst_ni, ram_we && ram_re && (ram_waddr == ram_raddr))
  // Walks never look past the end of the heap.
  `ASSERT_PROP(a_walk_in_heap, clk_i, rst_ni,
    (state_q == StWalk || state_q == StCoal) |-> !addr_q[ffha_pkg::PosW-1])
  // A result appears only on leaving the finish state.
  `ASSERT_PROP(a_result_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == StFin)

endmodule

[src/ffha_ram.sv]
// Generic simple dual-port RAM, one write and one registered read per cycle.
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the first-fit heap allocator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffha_pkg::*;

  localparam int NumRandom   = 1400;
  localparam int QuietTail   = 150;  // last random items run with no idling
  localparam int DrainCycles = 400;  // cycles watched for stray replies at the end
  localparam int MaxPrinted  = 50;
  localparam int UnitMask    = (1 << UnitShift) - 1;

  // One directed row. Where known is set the reply is typed in; otherwise the
  // heap predictor supplies it.
  typedef struct packed {
    logic            op;
    logic [ReqW-1:0] req;
    logic [OffW-1:0] foff;
    bit              known;
    logic            status;
    logic [OffW-1:0] offset;
  } dir_row_t;

  typedef struct packed {
    logic            status;
    logic [OffW-1:0] offset;
  } reply_t;

  localparam int NumDir = 24;
  localparam dir_row_t DirRows [NumDir] = '{
    // Fresh heap: a zero-byte request takes unit 0, payload at byte 16.
    '{OpAlloc, 16'd0,     15'd0,     1'b1, StatusOk,    15'd16},
    // Rounds to 4096 units, more than the whole heap.
    '{OpAlloc, 16'd32768, 15'd0,     1'b1, StatusNoFit, 15'd0},
    // Takes the rest exactly: leaves an empty free block at the heap end.
    '{OpAlloc, 16'd32720, 15'h7fff,  1'b1, StatusOk,    15'd32},
    // Only that empty block is free, too small even for a header.
    '{OpAlloc, 16'd0,     15'd0,     1'b1, StatusNoFit, 15'd0},
    // Free merges with the empty block behind it.
    '{OpFree,  16'hffff,  15'd32,    1'b1, StatusOk,    15'd0},
    // Already free.
    '{OpFree,  16'd0,     15'd32,    1'b1, StatusOk,    15'd0},
    // Unaligned, inside a header, top of the range, a header start.
    '{OpFree,  16'd0,     15'd17,    1'b1, StatusOk,    15'd0},
    '{OpFree,  16'd0,     15'd24,    1'b1, StatusOk,    15'd0},
    '{OpFree,  16'd0,     15'h7fff,  1'b1, StatusOk,    15'd0},
    '{OpFree,  16'd0,     15'd0,     1'b1, StatusOk,    15'd0},
    // Small requests carve the big free block in order.
    '{OpAlloc, 16'd1,     15'd0,     1'b1, StatusOk,    15'd32},
    '{OpAlloc, 16'd8,     15'd0,     1'b1, StatusOk,    15'd56},
    '{OpAlloc, 16'd9,     15'd0,     1'b1, StatusOk,    15'd80},
    // Punch a one-unit hole, then see which requests skip it.
    '{OpFree,  16'd0,     15'd56,    1'b1, StatusOk,    15'd0},
    '{OpAlloc, 16'd8,     15'h5555,  1'b0, StatusOk,    15'd0},
    '{OpAlloc, 16'd0,     15'h2aaa,  1'b0, StatusOk,    15'd0},
    // Two frees that merge with the hole.
    '{OpFree,  16'd0,     15'd16,    1'b1, StatusOk,    15'd0},
    '{OpFree,  16'd0,     15'd32,    1'b1, StatusOk,    15'd0},
    '{OpAlloc, 16'd32768, 15'd0,     1'b1, StatusNoFit, 15'd0},
    '{OpAlloc, 16'h7fff,  15'd0,     1'b1, StatusNoFit, 15'd0},
    '{OpFree,  16'd0,     15'd80,    1'b1, StatusOk,    15'd0},
    '{OpAlloc, 16'd24,    15'h2aaa,  1'b0, StatusOk,    15'd0},
    '{OpFree,  16'h5555,  15'd112,   1'b1, StatusOk,    15'd0},
    '{OpFree,  16'haaaa,  15'd136,   1'b1, StatusOk,    15'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ffha_req_if req_if ();
  ffha_rsp_if rsp_if ();

  first_fit_heap_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Heap predictor: one header per unit, meaningful only at block starts.
  // ---------------------------------------------------------------------------
  hdr_t heap_hdr [HeapUnits];

  function automatic void heap_clear();
    foreach (heap_hdr[i]) heap_hdr[i] = '0;
    heap_hdr[0] = '{used: 1'b0, size: SizeW'(HeapUnits - HeaderUnits)};
  endfunction

  // Merge every run of adjacent free blocks; stay on a merged block so that a
  // run of three or more folds into one.
  function automatic void merge_free_runs();
    int u;
    int n;
    u = 0;
    while (u < HeapUnits) begin
      n = u + HeaderUnits + int'(heap_hdr[u].size);
      if (n >= HeapUnits) break;
      if (!heap_hdr[u].used && !heap_hdr[n].used) begin
        heap_hdr[u].size = SizeW'(int'(heap_hdr[u].size) + HeaderUnits
                                  + int'(heap_hdr[n].size));
      end else begin
        u = n;
      end
    end
  endfunction

  // Apply one request to the predicted heap and return the reply it earns.
  function automatic reply_t heap_request(logic op, logic [ReqW-1:0] req,
                                          logic [OffW-1:0] foff);
    reply_t r;
    int     units;
    int     need;
    int     u;
    int     nx;
    int     rest;
    int     target;
    r.status = StatusOk;
    r.offset = '0;
    if (op == OpAlloc) begin
      units = (int'(req) + UnitMask) >> UnitShift;
      need  = units + HeaderUnits;
      u     = 0;
      while (u < HeapUnits) begin
        if (!heap_hdr[u].used && int'(heap_hdr[u].size) >= need) begin
          rest        = int'(heap_hdr[u].size) - need;
          heap_hdr[u] = '{used: 1'b1, size: SizeW'(units)};
          nx          = u + HeaderUnits + units;
          // Split off the remainder, even when it is empty.
          if (nx < HeapUnits) heap_hdr[nx] = '{used: 1'b0, size: SizeW'(rest)};
          r.offset = OffW'((u + HeaderUnits) << UnitShift);
          return r;
        end
        u = u + HeaderUnits + int'(heap_hdr[u].size);
      end
      r.status = StatusNoFit;
      return r;
    end
    // Free: only an aligned payload start of some block clears a used flag,
    // but the merge pass runs in every case.
    if ((int'(foff) & UnitMask) == 0) begin
      target = int'(foff) >> UnitShift;
      u      = 0;
      while (u < HeapUnits) begin
        if (u + HeaderUnits == target) begin
          heap_hdr[u].used = 1'b0;
          break;
        end
        u = u + HeaderUnits + int'(heap_hdr[u].size);
      end
    end
    merge_free_runs();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  reply_t      reply_q [$];    // replies owed by the block, oldest first
  logic [OffW-1:0] live_offs [$];  // payload offsets believed to be allocated
  int errors    = 0;
  int n_alloc   = 0;
  int n_nofit   = 0;
  int n_free    = 0;
  int n_replies = 0;

  int  gap_pct    = 20;  // chance of a sender gap before a transfer
  int  ready_pct  = 20;  // chance of a receiver stall burst starting
  bit  ready_calm = 1'b0;
  int  ready_hold = 0;

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= MaxPrinted) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stall bursts, none when calm.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || ready_calm) begin
      rsp_if.ready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      rsp_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < ready_pct) begin
      rsp_if.ready <= 1'b0;
      ready_hold = $urandom_range(0, 2);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Every reply transfer is matched against the oldest owed reply.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_replies++;
      if (reply_q.size() == 0) begin
        flag_mismatch($sformatf("reply with nothing owed: status %0d offset %0d",
                                rsp_if.status, rsp_if.payload_offset));
      end else begin
        want = reply_q.pop_front();
        if (rsp_if.status !== want.status)
          flag_mismatch($sformatf("reply %0d status %0b, want %0b",
                                  n_replies, rsp_if.status, want.status));
        if (rsp_if.payload_offset !== want.offset)
          flag_mismatch($sformatf("reply %0d payload_offset %0d, want %0d",
                                  n_replies, rsp_if.payload_offset, want.offset));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Drive one request, hold it until the transfer, then record what it owes.
  task automatic issue(logic op, logic [ReqW-1:0] req, logic [OffW-1:0] foff,
                       bit known, reply_t typed);
    reply_t got;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.op            <= op;
    req_if.request_bytes <= req;
    req_if.free_offset   <= foff;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    got = heap_request(op, req, foff);
    reply_q.push_back(known ? typed : got);
    if (op == OpFree) begin
      n_free++;
    end else begin
      n_alloc++;
      if (got.status == StatusNoFit) n_nofit++;
      else live_offs.push_back(got.offset);
    end
  endtask

  // Mostly small requests, some large, a few near or past the whole heap.
  function automatic logic [ReqW-1:0] pick_request_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5)  return '0;
    if (p < 70) return ReqW'($urandom_range(1, 128));
    if (p < 90) return ReqW'($urandom_range(129, 2048));
    if (p < 97) return ReqW'($urandom_range(2049, 16384));
    return ReqW'($urandom_range(16385, 32768));
  endfunction

  initial begin
    int              pick;
    int              free_bias;
    int              idx;
    logic [OffW-1:0] foff;

    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.op            = OpAlloc;
    req_if.request_bytes = '0;
    req_if.free_offset   = '0;
    heap_clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: extremes, exact fit, no fit and every odd free.
    foreach (DirRows[k]) begin
      issue(DirRows[k].op, DirRows[k].req, DirRows[k].foff, DirRows[k].known,
            reply_t'{status: DirRows[k].status, offset: DirRows[k].offset});
    end

    // Random traffic: mostly frees of live blocks and fresh allocations, with
    // noise frees mixed in. Every fourth hundred leans on frees so the heap
    // drains and big requests can fit again.
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       ready_pct = 0;
          1:       ready_pct = 15;
          default: ready_pct = 40;
        endcase
      end
      if (i >= NumRandom - QuietTail) begin
        gap_pct    = 0;
        ready_pct  = 0;
        ready_calm = 1'b1;
      end

      if ((i / 100) % 4 == 3)       free_bias = 85;
      else if (live_offs.size() > 40) free_bias = 70;
      else                          free_bias = 40;

      pick = $urandom_range(0, 99);
      if (pick < free_bias && live_offs.size() != 0) begin
        idx  = $urandom_range(0, live_offs.size() - 1);
        foff = live_offs[idx];
        live_offs.delete(idx);
        issue(OpFree, ReqW'($urandom_range(0, 32768)), foff, 1'b0, '0);
      end else if (pick >= free_bias && pick < free_bias + 8) begin
        // Noise: any offset, or any unit start (may hit a header or a block).
        if ($urandom_range(0, 1) == 0) foff = OffW'($urandom_range(0, 32767));
        else foff = OffW'($urandom_range(0, HeapUnits - 1) << UnitShift);
        issue(OpFree, ReqW'($urandom_range(0, 32768)), foff, 1'b0, '0);
      end else begin
        issue(OpAlloc, pick_request_size(), OffW'($urandom_range(0, 32767)), 1'b0, '0);
      end
    end
    req_if.valid <= 1'b0;

    // Let every owed reply arrive, then watch a while for strays.
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d allocations (%0d with no fit) and %0d frees,",
             n_alloc, n_nofit, n_free);
    $display("with %0d replies checked and %0d mismatches.", n_replies, errors);
    if (errors == 0) begin
      $display("** first_fit_heap_allocator: PASSED **");
    end else begin
      $display("** first_fit_heap_allocator: FAILED **");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run: every item a free that
  // walks a heap of 2048 header-only blocks twice, under the longest stalls.
  initial begin
    #500_000_000;
    $display("Timed out with %0d replies still owed.", reply_q.size());
    $display("** first_fit_heap_allocator: FAILED **");
    $finish;
  end

endmodule
